FILE: rtl/r2lab_pkg.sv
package r2lab_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Linear-light sRGB table, units of 1e-6 on a 0..100 scale.
    localparam int LIN_W = 27;
    localparam logic [LIN_W-1:0] LIN_TAB [256] = '{
        27'd0, 27'd30353, 27'd60705, 27'd91058, 27'd121411, 27'd151763, 27'd182116, 27'd212469,
        27'd242822, 27'd273174, 27'd303527, 27'd334654, 27'd367651, 27'd402472, 27'd439144,
        27'd477695, 27'd518152, 27'd560539, 27'd604883, 27'd651209, 27'd699541, 27'd749903,
        27'd802319, 27'd856813, 27'd913406, 27'd972122, 27'd1032982, 27'd1096009, 27'd1161225,
        27'd1228649, 27'd1298303, 27'd1370208, 27'd1444384, 27'd1520851, 27'd1599629,
        27'd1680738, 27'd1764195, 27'd1850022, 27'd1938236, 27'd2028856, 27'd2121901,
        27'd2217388, 27'd2315337, 27'd2415763, 27'd2518686, 27'd2624122, 27'd2732089,
        27'd2842604, 27'd2955683, 27'd3071344, 27'd3189603, 27'd3310477, 27'd3433981,
        27'd3560131, 27'd3688945, 27'd3820437, 27'd3954624, 27'd4091520, 27'd4231141,
        27'd4373503, 27'd4518620, 27'd4666509, 27'd4817182, 27'd4970657, 27'd5126946,
        27'd5286065, 27'd5448028, 27'd5612849, 27'd5780543, 27'd5951124, 27'd6124605,
        27'd6301002, 27'd6480327, 27'd6662594, 27'd6847817, 27'd7036010, 27'd7227185,
        27'd7421357, 27'd7618538, 27'd7818742, 27'd8021982, 27'd8228271, 27'd8437621,
        27'd8650046, 27'd8865559, 27'd9084171, 27'd9305896, 27'd9530747, 27'd9758735,
        27'd9989873, 27'd10224173, 27'd10461648, 27'd10702310, 27'd10946171, 27'd11193243,
        27'd11443537, 27'd11697067, 27'd11953843, 27'd12213877, 27'd12477182, 27'd12743768,
        27'd13013648, 27'd13286832, 27'd13563333, 27'd13843162, 27'd14126329, 27'd14412847,
        27'd14702727, 27'd14995979, 27'd15292615, 27'd15592646, 27'd15896084, 27'd16202938,
        27'd16513219, 27'd16826940, 27'd17144110, 27'd17464740, 27'd17788842, 27'd18116424,
        27'd18447499, 27'd18782077, 27'd19120168, 27'd19461783, 27'd19806932, 27'd20155625,
        27'd20507874, 27'd20863687, 27'd21223076, 27'd21586050, 27'd21952620, 27'd22322796,
        27'd22696587, 27'd23074005, 27'd23455058, 27'd23839757, 27'd24228112, 27'd24620133,
        27'd25015828, 27'd25415209, 27'd25818285, 27'd26225066, 27'd26635560, 27'd27049779,
        27'd27467731, 27'd27889426, 27'd28314874, 27'd28744084, 27'd29177065, 27'd29613827,
        27'd30054379, 27'd30498731, 27'd30946892, 27'd31398871, 27'd31854678, 27'd32314321,
        27'd32777810, 27'd33245154, 27'd33716362, 27'd34191442, 27'd34670406, 27'd35153260,
        27'd35640014, 27'd36130678, 27'd36625260, 27'd37123768, 27'd37626212, 27'd38132601,
        27'd38642943, 27'd39157248, 27'd39675523, 27'd40197778, 27'd40724021, 27'd41254261,
        27'd41788507, 27'd42326767, 27'd42869050, 27'd43415364, 27'd43965717, 27'd44520119,
        27'd45078578, 27'd45641102, 27'd46207700, 27'd46778380, 27'd47353150, 27'd47932018,
        27'd48514994, 27'd49102085, 27'd49693300, 27'd50288646, 27'd50888132, 27'd51491767,
        27'd52099557, 27'd52711513, 27'd53327640, 27'd53947949, 27'd54572446, 27'd55201140,
        27'd55834039, 27'd56471151, 27'd57112483, 27'd57758044, 27'd58407842, 27'd59061884,
        27'd59720179, 27'd60382734, 27'd61049557, 27'd61720656, 27'd62396039, 27'd63075714,
        27'd63759687, 27'd64447968, 27'd65140564, 27'd65837482, 27'd66538730, 27'd67244316,
        27'd67954247, 27'd68668531, 27'd69387176, 27'd70110189, 27'd70837578, 27'd71569350,
        27'd72305513, 27'd73046074, 27'd73791041, 27'd74540421, 27'd75294222, 27'd76052450,
        27'd76815115, 27'd77582222, 27'd78353779, 27'd79129794, 27'd79910274, 27'd80695226,
        27'd81484657, 27'd82278575, 27'd83076988, 27'd83879901, 27'd84687323, 27'd85499261,
        27'd86315721, 27'd87136712, 27'd87962240, 27'd88792312, 27'd89626935, 27'd90466117,
        27'd91309865, 27'd92158186, 27'd93011086, 27'd93868573, 27'd94730654, 27'd95597335,
        27'd96468625, 27'd97344529, 27'd98225055, 27'd99110210, 27'd100000000
    };

    // Matrix coefficients in units of 1e-4, rows X, Y, Z and columns R, G, B.
    localparam int SUM_W = 40;
    localparam logic [13:0] C_XR = 14'd4124;
    localparam logic [13:0] C_XG = 14'd3576;
    localparam logic [13:0] C_XB = 14'd1805;
    localparam logic [13:0] C_YR = 14'd2126;
    localparam logic [13:0] C_YG = 14'd7152;
    localparam logic [13:0] C_YB = 14'd722;
    localparam logic [13:0] C_ZR = 14'd193;
    localparam logic [13:0] C_ZG = 14'd1192;
    localparam logic [13:0] C_ZB = 14'd9505;

    // White point divisors, scaled to the product units of table times coefficient.
    localparam logic [63:0] DEN_X = 64'd950470000000;
    localparam logic [63:0] DEN_Y = 64'd1000000000000;
    localparam logic [63:0] DEN_Z = 64'd1088830000000;

    localparam logic [63:0] MEGA      = 64'd1000000;
    localparam logic [23:0] HALF_MEGA = 24'd500000;
    localparam logic [23:0] THR_PPM   = 24'd8856;
    localparam logic [23:0] LIN_MUL   = 24'd7787037;
    localparam logic [23:0] LIN_OFS   = 24'd137931;

endpackage

FILE: rtl/r2lab_cdiv.sv
module r2lab_cdiv #(
    parameter int          NW      = 57,
    parameter int          QW      = 17,
    parameter logic [63:0] DIVISOR = 64'd1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    output logic [QW-1:0] o_quot
);
    // Floor division by a constant in three stages. A reciprocal multiply on the
    // top bits of the dividend gives an estimate that is low by at most two. The
    // remainder of that estimate is formed in a narrow modular width, and two
    // compares against the divisor supply the missing count.
    localparam int DW = $clog2(DIVISOR + 64'd1);
    localparam int SH = DW - 1;
    localparam int HW = NW - SH;
    localparam int PW = 2 * HW + 1;
    localparam int EW = DW + 2;
    localparam logic [127:0]  RECIP = (128'd1 << NW) / 128'(DIVISOR);
    localparam logic [EW-1:0] D1    = EW'(DIVISOR);
    localparam logic [EW-1:0] D2    = EW'(DIVISOR << 1);

    logic [PW-1:0] w_prod;
    logic [EW-1:0] w_rem;
    logic [1:0]    w_fix;
    logic [QW-1:0] r_qe;
    logic [EW-1:0] r_nlo;
    logic [QW-1:0] r_qe2;
    logic [EW-1:0] r_rem;
    logic [QW-1:0] r_quot;

    assign w_prod = PW'(i_num[NW-1:SH]) * PW'(RECIP[HW:0]);
    assign w_rem  = r_nlo - EW'(r_qe) * D1;
    assign w_fix  = {1'b0, r_rem >= D1} + {1'b0, r_rem >= D2};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qe   <= QW'(w_prod >> HW);
            r_nlo  <= i_num[EW-1:0];
            r_qe2  <= r_qe;
            r_rem  <= w_rem;
            r_quot <= r_qe2 + QW'(w_fix);
        end
    end

    assign o_quot = r_quot;

endmodule

FILE: rtl/r2lab_cbrt.sv
module r2lab_cbrt #(
    parameter int FB = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [FB:0] i_v,
    output logic [FB+1:0] o_root
);
    // Digit-by-digit cube root of i_v * 2^(2*FB), one root bit per stage.
    localparam int S   = FB + 2;
    localparam int NB  = 3 * S;
    localparam int RW  = 2 * S + 6;
    localparam int Y2W = 2 * S;

    logic [NB-1:0]  a_num [S];
    logic [RW-1:0]  a_rem [S];
    logic [S-1:0]   a_y   [S];
    logic [Y2W-1:0] a_y2  [S];
    logic [RW-1:0]  n_rem [S];
    logic [S-1:0]   n_y   [S];
    logic [Y2W-1:0] n_y2  [S];
    logic [NB-1:0]  r_num [S];
    logic [RW-1:0]  r_rem [S];
    logic [S-1:0]   r_y   [S];
    logic [Y2W-1:0] r_y2  [S];

    for (genvar k = 0; k < S; k++) begin : g_stage
        logic [RW-1:0] w_sh;
        logic [RW-1:0] w_trial;
        if (k == 0) begin : g_first
            assign a_num[k] = NB'(i_v) << (2 * FB);
            assign a_rem[k] = '0;
            assign a_y[k]   = '0;
            assign a_y2[k]  = '0;
        end else begin : g_next
            assign a_num[k] = r_num[k-1];
            assign a_rem[k] = r_rem[k-1];
            assign a_y[k]   = r_y[k-1];
            assign a_y2[k]  = r_y2[k-1];
        end
        assign w_sh    = {a_rem[k][RW-4:0], a_num[k][NB-1-3*k -: 3]};
        // Cost of appending a one bit: 12*y^2 + 6*y + 1.
        assign w_trial = (RW'(a_y2[k]) << 3) + (RW'(a_y2[k]) << 2)
                       + (RW'(a_y[k]) << 2) + (RW'(a_y[k]) << 1) + RW'(1);
        always_comb begin
            if (w_sh >= w_trial) begin
                n_rem[k] = w_sh - w_trial;
                n_y[k]   = {a_y[k][S-2:0], 1'b1};
                n_y2[k]  = (a_y2[k] << 2) + (Y2W'(a_y[k]) << 2) + Y2W'(1);
            end else begin
                n_rem[k] = w_sh;
                n_y[k]   = {a_y[k][S-2:0], 1'b0};
                n_y2[k]  = a_y2[k] << 2;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= a_num[k];
                r_rem[k] <= n_rem[k];
                r_y[k]   <= n_y[k];
                r_y2[k]  <= n_y2[k];
            end
        end
    end

    assign o_root = r_y[S-1];

endmodule

FILE: rtl/rgb565_to_cielab.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_pixel[15:0] (R 15..11, G 10..5, B 4..0)
// output    out        o_valid / i_ready    o_lightness[6:0], o_green_red[7:0],
//                                           o_blue_yellow[7:0]
//
// One item enters per clock while o_ready is high, that is while the skid register is free.
// The cube root sets most of the pipeline depth (one root bit per stage); the white point
// normalization and the linear branch of f() divide by constants through a reciprocal
// multiply in three stages each.
// Reset is synchronous and active low; it empties the pipeline and the output side.
// When the output stalls, the last item moves into a skid register, and only then
// does the whole pipeline hold; nothing is dropped or repeated.
module rgb565_to_cielab #(
    parameter int FRAC_BITS = r2lab_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [15:0]       i_pixel,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [6:0]        o_lightness,
    output logic signed [7:0] o_green_red,
    output logic signed [7:0] o_blue_yellow
);
    import r2lab_pkg::*;

    localparam int FB  = FRAC_BITS;
    localparam int NNW = SUM_W + FB + 1;  // normalization dividend
    localparam int LNW = FB + 22;         // linear-branch dividend
    localparam int TW  = FB + 21;         // threshold compare
    localparam int VL  = FB + 9;          // pipeline stages ahead of the output register
    localparam int AW  = FB + 13;         // a and b products

    // The whole pipeline advances while the skid register is free.
    logic w_en;
    logic r_skid_vld;
    logic [VL-1:0] r_vld;

    assign w_en    = ~r_skid_vld;
    assign o_ready = w_en;

    // Stage 1: widen the channels by bit replication and linearize through the table.
    logic [LIN_W-1:0] r_lin [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin[0] <= LIN_TAB[{i_pixel[15:11], i_pixel[15:13]}];
            r_lin[1] <= LIN_TAB[{i_pixel[10:5], i_pixel[10:9]}];
            r_lin[2] <= LIN_TAB[{i_pixel[4:0], i_pixel[4:2]}];
        end
    end

    // Stage 2: the 3x3 matrix.
    logic [SUM_W-1:0] r_sum [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum[0] <= SUM_W'(r_lin[0]) * SUM_W'(C_XR) + SUM_W'(r_lin[1]) * SUM_W'(C_XG)
                      + SUM_W'(r_lin[2]) * SUM_W'(C_XB);
            r_sum[1] <= SUM_W'(r_lin[0]) * SUM_W'(C_YR) + SUM_W'(r_lin[1]) * SUM_W'(C_YG)
                      + SUM_W'(r_lin[2]) * SUM_W'(C_YB);
            r_sum[2] <= SUM_W'(r_lin[0]) * SUM_W'(C_ZR) + SUM_W'(r_lin[1]) * SUM_W'(C_ZG)
                      + SUM_W'(r_lin[2]) * SUM_W'(C_ZB);
        end
    end

    // Stage 3: dividends for round-to-nearest normalization.
    logic [NNW-1:0] r_nnum [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nnum[0] <= (NNW'(r_sum[0]) << FB) + NNW'(DEN_X >> 1);
            r_nnum[1] <= (NNW'(r_sum[1]) << FB) + NNW'(DEN_Y >> 1);
            r_nnum[2] <= (NNW'(r_sum[2]) << FB) + NNW'(DEN_Z >> 1);
        end
    end

    logic [FB:0]   w_v    [3];
    logic [FB+1:0] w_root [3];
    logic [FB:0]   w_lin  [3];
    logic [FB:0]   w_lin_d [3];
    logic          w_thr  [3];
    logic [LNW-1:0] r_lnum [3];
    logic [2:0]    r_flg  [FB+2];

    r2lab_cdiv #(.NW(NNW), .QW(FB + 1), .DIVISOR(DEN_X)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_nnum[0]), .o_quot(w_v[0])
    );
    r2lab_cdiv #(.NW(NNW), .QW(FB + 1), .DIVISOR(DEN_Y)) u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_nnum[1]), .o_quot(w_v[1])
    );
    r2lab_cdiv #(.NW(NNW), .QW(FB + 1), .DIVISOR(DEN_Z)) u_div_z (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_nnum[2]), .o_quot(w_v[2])
    );

    // Both branches of f() run side by side with equal depth; the threshold
    // flag travels alongside and picks one at the end.
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [FB:0] r_ldly [FB-2];

        r2lab_cbrt #(.FB(FB)) u_cbrt (
            .i_clk(i_clk), .i_en(w_en), .i_v(w_v[c]), .o_root(w_root[c])
        );

        assign w_thr[c] = (TW'(w_v[c]) * TW'(MEGA)) > (TW'(THR_PPM) << FB);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_lnum[c] <= LNW'(w_v[c]) * LNW'(LIN_MUL) + (LNW'(LIN_OFS) << FB)
                           + LNW'(HALF_MEGA);
            end
        end

        r2lab_cdiv #(.NW(LNW), .QW(FB + 1), .DIVISOR(MEGA)) u_div_lin (
            .i_clk(i_clk), .i_en(w_en), .i_num(r_lnum[c]), .o_quot(w_lin[c])
        );

        // The linear branch settles sooner than the cube root, so its result
        // waits here until the root catches up.
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ldly[0] <= w_lin[c];
                for (int k = 1; k < FB - 2; k++) begin
                    r_ldly[k] <= r_ldly[k-1];
                end
            end
        end

        assign w_lin_d[c] = r_ldly[FB-3];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flg[0] <= {w_thr[2], w_thr[1], w_thr[0]};
        end
    end

    for (genvar k = 1; k < FB + 2; k++) begin : g_flg
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    logic [FB+1:0] w_f [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_f[c] = r_flg[FB+1][c] ? w_root[c] : (FB+2)'(w_lin_d[c]);
        end
    end

    // Final stage: scale, floor and saturate.
    logic [FB+8:0]       w_pl;
    logic [8:0]          w_ql;
    logic signed [FB+2:0] w_da;
    logic signed [FB+2:0] w_db;
    logic signed [AW-1:0] w_pa;
    logic signed [AW-1:0] w_pb;
    logic signed [11:0]  w_qa;
    logic signed [11:0]  w_qb;
    logic [6:0]          n_l;
    logic [7:0]          n_a;
    logic [7:0]          n_b;
    logic [6:0]          r_l;
    logic [7:0]          r_a;
    logic [7:0]          r_b;

    always_comb begin
        w_pl = (FB+9)'(w_f[1]) * (FB+9)'(116);
        w_ql = w_pl[FB+8:FB];
        if (w_ql < 9'd16) begin
            n_l = 7'd0;
        end else if (w_ql > 9'd116) begin
            n_l = 7'd100;
        end else begin
            n_l = 7'(w_ql - 9'd16);
        end

        w_da = $signed({1'b0, w_f[0]}) - $signed({1'b0, w_f[1]});
        w_db = $signed({1'b0, w_f[1]}) - $signed({1'b0, w_f[2]});
        w_pa = AW'(w_da) * AW'(500);
        w_pb = AW'(w_db) * AW'(200);
        // An arithmetic shift floors toward minus infinity.
        w_qa = $signed(w_pa[FB+11:FB]);
        w_qb = $signed(w_pb[FB+11:FB]);
        if (w_qa < -12'sd128) begin
            n_a = 8'h80;
        end else if (w_qa > 12'sd127) begin
            n_a = 8'h7f;
        end else begin
            n_a = w_qa[7:0];
        end
        if (w_qb < -12'sd128) begin
            n_b = 8'h80;
        end else if (w_qb > 12'sd127) begin
            n_b = 8'h7f;
        end else begin
            n_b = w_qb[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l <= n_l;
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    // Output register with a skid register behind it.
    logic       r_out_vld;
    logic [6:0] r_skid_l;
    logic [7:0] r_skid_a;
    logic [7:0] r_skid_b;
    logic [6:0] r_out_l;
    logic [7:0] r_out_a;
    logic [7:0] r_out_b;
    logic       n_out_vld;
    logic       n_skid_vld;
    logic       w_take;

    assign w_take = ~r_out_vld | i_ready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (w_en) begin
            if (w_take) begin
                n_out_vld = r_vld[VL-1];
            end else begin
                n_skid_vld = r_vld[VL-1];
            end
        end else if (i_ready) begin
            n_out_vld  = 1'b1;
            n_skid_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[VL-2:0], i_valid};
            end
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_take) begin
                r_out_l <= r_l;
                r_out_a <= r_a;
                r_out_b <= r_b;
            end else begin
                r_skid_l <= r_l;
                r_skid_a <= r_a;
                r_skid_b <= r_b;
            end
        end else if (i_ready) begin
            r_out_l <= r_skid_l;
            r_out_a <= r_skid_a;
            r_out_b <= r_skid_b;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_lightness   = r_out_l;
    assign o_green_red   = $signed(r_out_a);
    assign o_blue_yellow = $signed(r_out_b);

endmodule

FILE: rtl/r2lab_chk.sv
module r2lab_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [15:0]       i_pixel,
    input logic              o_valid,
    input logic              i_ready,
    input logic [6:0]        o_lightness,
    input logic signed [7:0] o_green_red,
    input logic signed [7:0] o_blue_yellow
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_l_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_lightness <= 7'd100)
        else $error("lightness above 100");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_lightness) && $stable(o_green_red)
                                && $stable(o_blue_yellow))
        else $error("output item changed while stalled");

endmodule

bind rgb565_to_cielab r2lab_chk u_chk (.*);

FILE: tb/tb_rgb565_to_cielab.sv
`timescale 1ns / 1ps

module tb_rgb565_to_cielab;
    import r2lab_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    // Pipeline depth of the block; the final drain waits a little longer.
    localparam int LATENCY = FB + 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [6:0]        lightness;
        logic signed [7:0] green_red;
        logic signed [7:0] blue_yellow;
    } t_lab;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [15:0]       i_pixel = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [6:0]        o_lightness;
    logic signed [7:0] o_green_red;
    logic signed [7:0] o_blue_yellow;

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    always #2 i_clk = ~i_clk;

    rgb565_to_cielab #(.FRAC_BITS(FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_pixel(i_pixel),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_lightness(o_lightness), .o_green_red(o_green_red),
        .o_blue_yellow(o_blue_yellow)
    );

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // The CIELAB f(): a cube root of the normalized value above the
    // threshold, and the straight line below it, all in fixed point.
    function automatic logic [63:0] cielab_f(input logic [63:0] v);
        logic [127:0] target;
        logic [127:0] cand;
        logic [63:0]  root;
        root = '0;
        if (v * 64'd1000000 > (64'd8856 << FB)) begin
            target = {64'd0, v} << (2 * FB);
            for (int k = FB + 1; k >= 0; k--) begin
                cand = {64'd0, root | (64'd1 << k)};
                if (cand * cand * cand <= target) begin
                    root = cand[63:0];
                end
            end
            return root;
        end
        return (v * 64'd7787037 + (64'd137931 << FB) + 64'd500000) / 64'd1000000;
    endfunction

    // floor(k * d / 2^FB), clamped; an arithmetic shift floors toward minus infinity.
    function automatic longint floor_clamp(input longint k, input longint d,
                                           input longint lo, input longint hi);
        longint q;
        q = (k * d) >>> FB;
        if (q < lo) q = lo;
        if (q > hi) q = hi;
        return q;
    endfunction

    function automatic t_lab pixel_to_lab(input logic [15:0] px);
        logic [4:0]   r5;
        logic [5:0]   g6;
        logic [4:0]   b5;
        logic [127:0] rl, gl, bl, sx, sy, sz;
        longint       fx, fy, fz, lv, av, bv;
        t_lab         res;
        r5 = px[15:11];
        g6 = px[10:5];
        b5 = px[4:0];
        // Widen to 8 bits by replicating the top bits into the bottom.
        rl = 128'(LIN_TAB[{r5, r5[4:2]}]);
        gl = 128'(LIN_TAB[{g6, g6[5:4]}]);
        bl = 128'(LIN_TAB[{b5, b5[4:2]}]);
        sx = rl * 4124 + gl * 3576 + bl * 1805;
        sy = rl * 2126 + gl * 7152 + bl * 722;
        sz = rl * 193 + gl * 1192 + bl * 9505;
        fx = longint'(cielab_f(64'(((sx << FB) + 128'(DEN_X) / 2) / 128'(DEN_X))));
        fy = longint'(cielab_f(64'(((sy << FB) + 128'(DEN_Y) / 2) / 128'(DEN_Y))));
        fz = longint'(cielab_f(64'(((sz << FB) + 128'(DEN_Z) / 2) / 128'(DEN_Z))));
        lv = floor_clamp(116, fy, -1000, 1000) - 16;
        av = floor_clamp(500, fx - fy, -128, 127);
        bv = floor_clamp(200, fy - fz, -128, 127);
        if (lv < 0) lv = 0;
        if (lv > 100) lv = 100;
        res.lightness = lv[6:0];
        res.green_red = av[7:0];
        res.blue_yellow = bv[7:0];
        return res;
    endfunction

    class t_lab_scoreboard;
        t_lab pending_lab[$];
        logic [15:0] pending_px[$];

        function void note_pixel(logic [15:0] px);
            pending_lab.push_back(pixel_to_lab(px));
            pending_px.push_back(px);
        endfunction

        task check_lab(t_lab got);
            t_lab want;
            logic [15:0] px;
            if (pending_lab.size() == 0) begin
                report_mismatch($sformatf("unexpected item L=%0d a=%0d b=%0d",
                                          got.lightness, got.green_red, got.blue_yellow));
                return;
            end
            want = pending_lab.pop_front();
            px = pending_px.pop_front();
            if (got.lightness !== want.lightness)
                report_mismatch($sformatf("pixel %h L got %0d want %0d",
                                          px, got.lightness, want.lightness));
            if (got.green_red !== want.green_red)
                report_mismatch($sformatf("pixel %h a got %0d want %0d",
                                          px, got.green_red, want.green_red));
            if (got.blue_yellow !== want.blue_yellow)
                report_mismatch($sformatf("pixel %h b got %0d want %0d",
                                          px, got.blue_yellow, want.blue_yellow));
        endtask
    endclass

    t_lab_scoreboard lab_sb = new();

    // Handshakes are sampled mid-cycle, where every signal is settled, and
    // stand for the transfer at the following rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                lab_sb.note_pixel(i_pixel);
            if (o_valid && i_ready)
                lab_sb.check_lab('{o_lightness, o_green_red, o_blue_yellow});
        end
    end

    // The receiver stalls at random with the probability of the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_rgb565_to_cielab NOT OK");
            $finish;
        end
    end

    // Offers one pixel, possibly after random idle cycles, and returns at the
    // rising edge that accepts it.
    task automatic send_pixel(input logic [15:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(negedge i_clk); while (!(i_valid && o_ready));
        @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (lab_sb.pending_lab.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items, input int idle_pct, input int stall_pct);
        logic [15:0] px;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(3))
                // Dark colors keep some channels on the linear branch of f().
                0: px = {2'b00, 3'($urandom_range(7, 0)), 3'b000, 3'($urandom_range(7, 0)),
                         2'b00, 3'($urandom_range(7, 0))};
                // Saturated primaries and mixes push a and b to their clamps.
                1: px = {$urandom_range(1) ? 5'h1f : 5'($urandom_range(31)),
                         $urandom_range(1) ? 6'h00 : 6'($urandom_range(63)),
                         $urandom_range(1) ? 5'h1f : 5'h00};
                default: px = 16'($urandom);
            endcase
            send_pixel(px);
        end
    endtask

    initial begin
        logic [15:0] directed [$];
        directed = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f, 16'hffe0,
                     16'h07ff, 16'hf81f, 16'h0821, 16'h8410, 16'h0020, 16'h0800};
        for (int k = 0; k < 16; k++)
            directed.push_back(16'h1 << k);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels: black, white, the primaries and secondaries, grays,
        // and every single bit, with neither side idling.
        foreach (directed[k])
            send_pixel(directed[k]);
        // Hold off until the block has delivered everything, then resume.
        drain();

        random_phase(265, 0, 0);
        random_phase(260, 84, 0);
        random_phase(260, 0, 84);
        random_phase(265, 10, 10);

        drain();
        recv_stall_pct = 0;
        repeat (LATENCY + 20) @(posedge i_clk);
        if (lab_sb.pending_lab.size() != 0)
            report_mismatch("expected items never arrived");

        if (mismatches == 0) begin
            $display("tb_rgb565_to_cielab OK");
        end else begin
            $display("tb_rgb565_to_cielab NOT OK");
        end
        $finish;
    end

endmodule
